[rtl/mla_pkg.sv]
// Shared constants, types and helpers for the mean luma accumulator.
package mla_pkg;

   localparam int unsigned MAX_SIDE   = 4096;
   localparam int unsigned REG_W      = 13;
   localparam int unsigned COMP_W     = 8;
   localparam int unsigned WEIGHT_W   = 16;
   localparam int unsigned PROD_W     = WEIGHT_W + REG_W;
   localparam int unsigned LUMA_W     = 24;
   localparam int unsigned SUM_W      = 48;
   localparam int unsigned COUNT_W    = 24;
   localparam int unsigned TOTAL_W    = COUNT_W + 1;
   localparam int unsigned MEAN_W     = 24;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned DIV_CNT_W  = $clog2(SUM_W);

   localparam logic [WEIGHT_W-1:0] W_RED   = WEIGHT_W'(19595);
   localparam logic [WEIGHT_W-1:0] W_GREEN = WEIGHT_W'(38470);
   localparam logic [WEIGHT_W-1:0] W_BLUE  = WEIGHT_W'(7471);
   localparam logic [MEAN_W-1:0]   LUMA_MAX = MEAN_W'(16711680);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = CSR_IDX_W'(1);

   typedef logic [REG_W-1:0] side_type;

   // zero reads as one, oversize clamps to MAX_SIDE
   function automatic side_type side_of(input side_type reg_value);
      side_type v;
      v = reg_value;
      if (v == '0) begin
         v = REG_W'(1);
      end else if (v > REG_W'(MAX_SIDE)) begin
         v = REG_W'(MAX_SIDE);
      end
      return v;
   endfunction

endpackage

[rtl/mla_if.sv]
// Handshake channel interfaces: pixel input, mean result, register writes.
interface mla_req_if;
   logic                           valid;
   logic                           ready;
   logic [mla_pkg::COMP_W-1:0]     blue;
   logic [mla_pkg::COMP_W-1:0]     green;
   logic [mla_pkg::COMP_W-1:0]     red;
   modport source (output valid, blue, green, red, input ready);
   modport sink   (input valid, blue, green, red, output ready);
endinterface

interface mla_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [mla_pkg::MEAN_W-1:0]     mean_luma;
   modport source (output valid, mean_luma, input ready);
   modport sink   (input valid, mean_luma, output ready);
endinterface

interface mla_csr_if;
   logic                           valid;
   logic                           ready;
   logic [mla_pkg::CSR_IDX_W-1:0]  index;
   logic [mla_pkg::REG_W-1:0]      data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/mla_divider.sv]
// Restoring divider: one quotient bit per cycle, sum over pixel total.
module mla_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [mla_pkg::SUM_W-1:0]      dividend,
   input  logic [mla_pkg::TOTAL_W-1:0]    divisor,
   output logic                           done,
   output logic [mla_pkg::SUM_W-1:0]      quotient
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [mla_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [mla_pkg::TOTAL_W-1:0]       rem_ff, rem_in;
   logic [mla_pkg::SUM_W-1:0]         quo_ff, quo_in;
   logic [mla_pkg::TOTAL_W-1:0]       divisor_ff, divisor_in;
   logic [mla_pkg::TOTAL_W:0]         shifted;
   logic [mla_pkg::TOTAL_W:0]         diff;
   logic                              fits;

   assign shifted = {rem_ff, quo_ff[mla_pkg::SUM_W-1]};
   assign diff    = shifted - {1'b0, divisor_ff};
   assign fits    = shifted >= {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         cnt_in     = '0;
         rem_in     = '0;
         quo_in     = dividend;
         divisor_in = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[mla_pkg::TOTAL_W-1:0] : shifted[mla_pkg::TOTAL_W-1:0];
         quo_in = {quo_ff[mla_pkg::SUM_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == mla_pkg::DIV_CNT_W'(mla_pkg::SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[rtl/mean_luma_accumulator.sv]
// Top level: frame mean of BT.601 luma over a shared multiplier and divider.
//
//  channel  | dir | payload                     | transfer when
//  req_ch   | in  | blue, green, red (8b each)  | valid && ready
//  rsp_ch   | out | mean_luma (24b, 8.16)       | valid && ready
//  csr_ch   | in  | index (1b), data (13b)      | valid && ready (ready tied high)
//
// A pixel is accepted in S_IDLE, then makes 4 passes through the 16x13 multiplier
// (red, green, blue weights, then width*height) and one accumulate/compare.
// The last pixel of a frame also waits for the previous mean to leave the
// output register, then launches the divider and takes its quotient when
// the divider is done.
// Synchronous reset clears the sum and count and sets both sizes to 1.
// A stalled rsp_ch holds only the result; pixels keep flowing until the
// next frame's division would need the output register.
module mean_luma_accumulator (
   input  logic           clock,
   input  logic           reset,
   mla_req_if.sink        req_ch,
   mla_rsp_if.source      rsp_ch,
   mla_csr_if.sink        csr_ch
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_SUM  = 3'd2;
   localparam logic [2:0] S_WAIT = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;

   logic [2:0]                         state_ff, state_in;
   logic [1:0]                         step_ff, step_in;
   logic [mla_pkg::REG_W-1:0]          width_ff, width_in;
   logic [mla_pkg::REG_W-1:0]          height_ff, height_in;
   logic [mla_pkg::COMP_W-1:0]         blue_ff, blue_in;
   logic [mla_pkg::COMP_W-1:0]         green_ff, green_in;
   logic [mla_pkg::COMP_W-1:0]         red_ff, red_in;
   logic [mla_pkg::LUMA_W-1:0]         luma_ff, luma_in;
   logic [mla_pkg::TOTAL_W-1:0]        total_ff, total_in;
   logic [mla_pkg::SUM_W-1:0]          sum_ff, sum_in;
   logic [mla_pkg::COUNT_W-1:0]        count_ff, count_in;
   logic [mla_pkg::SUM_W-1:0]          dividend_ff, dividend_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [mla_pkg::MEAN_W-1:0]         mean_ff, mean_in;

   logic [mla_pkg::WEIGHT_W-1:0]       mul_a;
   logic [mla_pkg::REG_W-1:0]          mul_b;
   logic [mla_pkg::PROD_W-1:0]         product;
   logic [mla_pkg::TOTAL_W-1:0]        taken;
   logic                               div_start;
   logic                               div_done;
   logic [mla_pkg::SUM_W-1:0]          quotient;
   logic                               req_xfer;
   logic                               rsp_xfer;

   assign req_xfer = req_ch.valid && req_ch.ready;
   assign rsp_xfer = rsp_valid_ff && rsp_ch.ready;

   // shared multiplier operand select
   always_comb begin
      case (step_ff)
         2'd0: begin
            mul_a = mla_pkg::W_RED;
            mul_b = mla_pkg::REG_W'(red_ff);
         end
         2'd1: begin
            mul_a = mla_pkg::W_GREEN;
            mul_b = mla_pkg::REG_W'(green_ff);
         end
         2'd2: begin
            mul_a = mla_pkg::W_BLUE;
            mul_b = mla_pkg::REG_W'(blue_ff);
         end
         default: begin
            mul_a = mla_pkg::WEIGHT_W'(mla_pkg::side_of(width_ff));
            mul_b = mla_pkg::side_of(height_ff);
         end
      endcase
   end

   assign product = mla_pkg::PROD_W'(mul_a) * mla_pkg::PROD_W'(mul_b);
   assign taken   = mla_pkg::TOTAL_W'(count_ff) + 1'b1;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      blue_in      = blue_ff;
      green_in     = green_ff;
      red_in       = red_ff;
      luma_in      = luma_ff;
      total_in     = total_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      dividend_in  = dividend_ff;
      rsp_valid_in = rsp_valid_ff;
      mean_in      = mean_ff;
      div_start    = 1'b0;

      if (csr_ch.valid) begin
         if (csr_ch.index == mla_pkg::CSR_IMAGE_WIDTH) begin
            width_in = csr_ch.data;
         end else if (csr_ch.index == mla_pkg::CSR_IMAGE_HEIGHT) begin
            height_in = csr_ch.data;
         end
      end

      if (rsp_xfer) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               blue_in  = req_ch.blue;
               green_in = req_ch.green;
               red_in   = req_ch.red;
               luma_in  = '0;
               step_in  = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            if (step_ff == 2'd3) begin
               total_in = product[mla_pkg::TOTAL_W-1:0];
               state_in = S_SUM;
            end else begin
               luma_in = luma_ff + product[mla_pkg::LUMA_W-1:0];
            end
            step_in = step_ff + 1'b1;
         end
         S_SUM: begin
            if (taken >= total_ff) begin
               dividend_in = sum_ff + mla_pkg::SUM_W'(luma_ff);
               sum_in      = '0;
               count_in    = '0;
               state_in    = S_WAIT;
            end else begin
               sum_in   = sum_ff + mla_pkg::SUM_W'(luma_ff);
               count_in = taken[mla_pkg::COUNT_W-1:0];
               state_in = S_IDLE;
            end
         end
         S_WAIT: begin
            if (!rsp_valid_ff) begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               rsp_valid_in = 1'b1;
               mean_in = (quotient > mla_pkg::SUM_W'(mla_pkg::LUMA_MAX)) ?
                         mla_pkg::LUMA_MAX : quotient[mla_pkg::MEAN_W-1:0];
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         width_ff     <= mla_pkg::REG_W'(1);
         height_ff    <= mla_pkg::REG_W'(1);
         sum_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      blue_ff     <= blue_in;
      green_ff    <= green_in;
      red_ff      <= red_in;
      luma_ff     <= luma_in;
      total_ff    <= total_in;
      dividend_ff <= dividend_in;
      mean_ff     <= mean_in;
   end

   mla_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend_ff),
      .divisor  (total_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign req_ch.ready     = (state_ff == S_IDLE);
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.mean_luma = mean_ff;
   assign csr_ch.ready     = 1'b1;

endmodule

[rtl/mla_checker.sv]
// Port-level checks for the mean luma accumulator, bound to the top level.
module mla_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [mla_pkg::MEAN_W-1:0]  rsp_mean_luma,
   input  logic                        csr_valid,
   input  logic                        csr_ready
);

   // a held result keeps its value until the transfer
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mean_luma))
      else $error("mean result changed while stalled");

   // one pixel at a time: busy right after taking one
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("pixel accepted while previous still in work");

   // mean never exceeds full-scale luma
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_mean_luma <= mla_pkg::LUMA_MAX)
      else $error("mean above full scale");

   // a new result cannot follow a transfer in the very next cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid)
      else $error("back-to-back results");

   // register writes are never stalled
   assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write stalled");

endmodule

bind mean_luma_accumulator mla_checker u_mla_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_mean_luma (rsp_ch.mean_luma),
   .csr_valid     (csr_ch.valid),
   .csr_ready     (csr_ch.ready)
);
